/* rtl/hco_pkg.sv */
// Shared types and constants for the hardware cursor overlay.
// No dependencies; every other file of the block but hco_ram imports this package.
package hco_pkg;

  localparam int COLOUR_W = 24;
  localparam int POS_W    = 16;
  localparam int COORD_W  = 11;
  localparam int ADDR_W   = 10;
  localparam int BYTE_W   = 8;

  // Each bit plane is its own 512-byte memory, 8 bytes per 64-pixel row.
  localparam int PLANE_DEPTH = 512;
  localparam int INDEX_W     = 9;

  // Signed window offset: column = x + 64 - pos_x, which fits in 17 signed bits.
  localparam int OFS_W      = 18;
  localparam int WIN_OFFSET = 64;

  localparam logic [COLOUR_W-1:0] COLOUR_MASK = 24'hffffff;

  localparam int CFG_INDEX_W = 3;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_MODE     = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_BIG      = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_QUADRANT = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_POS_X    = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_POS_Y    = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_COLOUR1  = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_COLOUR2  = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_COLOUR3  = 3'd7;

  // Cursor display modes.
  localparam logic [1:0] MODE_OFF    = 2'd0;
  localparam logic [1:0] MODE_THREE  = 2'd1;
  localparam logic [1:0] MODE_XGA    = 2'd2;
  localparam logic [1:0] MODE_XWIN   = 2'd3;

  // Item kinds.
  localparam logic OP_STORE = 1'b0;
  localparam logic OP_PIXEL = 1'b1;

  typedef struct packed {
    logic [1:0]          mode;
    logic                big;
    logic [1:0]          quadrant;
    logic [POS_W-1:0]    pos_x;
    logic [POS_W-1:0]    pos_y;
    logic [COLOUR_W-1:0] colour_one;
    logic [COLOUR_W-1:0] colour_two;
    logic [COLOUR_W-1:0] colour_three;
  } cfg_t;

  // A classified item as it travels from the front to the back.
  typedef struct packed {
    logic                is_pixel;
    logic                hit;
    logic                plane;
    logic [INDEX_W-1:0]  index;
    logic [2:0]          bitsel;
    logic [BYTE_W-1:0]   wbyte;
    logic [COLOUR_W-1:0] colour;
  } entry_t;

endpackage

/* rtl/hco_in_if.sv */
// Input channel of the cursor overlay: valid/ready plus the item fields.
// Depends on hco_pkg for the field widths.
interface hco_in_if;
  import hco_pkg::*;

  logic                valid;
  logic                ready;
  logic                op;
  logic [ADDR_W-1:0]   store_addr;
  logic [BYTE_W-1:0]   store_byte;
  logic [COORD_W-1:0]  pixel_x;
  logic [COORD_W-1:0]  pixel_y;
  logic [COLOUR_W-1:0] pixel_colour;

  modport source (
    output valid, op, store_addr, store_byte, pixel_x, pixel_y, pixel_colour,
    input  ready
  );
  modport sink (
    input  valid, op, store_addr, store_byte, pixel_x, pixel_y, pixel_colour,
    output ready
  );
endinterface

/* rtl/hco_out_if.sv */
// Result channel of the cursor overlay: valid/ready plus the final colour.
// Depends on hco_pkg for the colour width.
interface hco_out_if;
  import hco_pkg::*;

  logic                valid;
  logic                ready;
  logic [COLOUR_W-1:0] out_colour;

  modport source (output valid, out_colour, input ready);
  modport sink (input valid, out_colour, output ready);
endinterface

/* rtl/hco_ram.sv */
// Generic simple dual-port RAM with one write port and a registered read.
// Self-contained; no package needed.
module hco_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

/* rtl/hco_front.sv */
// Front end: accepts items and classifies them (window test, store index).
// Depends on hco_pkg and hco_in_if.
module hco_front (
  hco_in_if.sink             item,
  input  hco_pkg::cfg_t      cfg,
  input  logic               clearing,
  input  logic               push_ready,
  output logic               push_valid,
  output hco_pkg::entry_t    push_entry
);
  import hco_pkg::*;

  logic signed [OFS_W-1:0] col;
  logic signed [OFS_W-1:0] row;
  logic                    in_x;
  logic                    in_y;
  logic [5:0]              col6;
  logic [5:0]              row6;

  assign item.ready = push_ready && !clearing;
  assign push_valid = item.valid && !clearing;

  always_comb begin
    col = $signed({{(OFS_W-COORD_W){1'b0}}, item.pixel_x}) + OFS_W'(WIN_OFFSET)
          - $signed({{(OFS_W-POS_W){1'b0}}, cfg.pos_x});
    row = $signed({{(OFS_W-COORD_W){1'b0}}, item.pixel_y}) + OFS_W'(WIN_OFFSET)
          - $signed({{(OFS_W-POS_W){1'b0}}, cfg.pos_y});
    // Inside means 0 <= offset < 64, or < 32 for the quadrant images.
    in_x = !col[OFS_W-1] && (col[OFS_W-2:6] == '0) && (cfg.big || !col[5]);
    in_y = !row[OFS_W-1] && (row[OFS_W-2:6] == '0) && (cfg.big || !row[5]);
    col6 = cfg.big ? col[5:0] : {cfg.quadrant[0], col[4:0]};
    row6 = cfg.big ? row[5:0] : {cfg.quadrant[1], row[4:0]};

    push_entry.is_pixel = (item.op == OP_PIXEL);
    push_entry.hit      = in_x && in_y;
    push_entry.colour   = item.pixel_colour;
    push_entry.wbyte    = item.store_byte;
    push_entry.bitsel   = col6[2:0];
    if (item.op == OP_PIXEL) begin
      push_entry.plane = 1'b0;
      push_entry.index = {row6, col6[5:3]};
    end else begin
      push_entry.plane = item.store_addr[ADDR_W-1];
      push_entry.index = item.store_addr[INDEX_W-1:0];
    end
  end
endmodule

/* rtl/hco_queue.sv */
// Two-entry queue of classified items between the front and the back.
// Depends on hco_pkg.
module hco_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push_valid,
  input  hco_pkg::entry_t push_entry,
  output logic            push_ready,
  output logic            head_valid,
  output hco_pkg::entry_t head,
  input  logic            pop
);
  import hco_pkg::*;

  entry_t     slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;

  assign push_ready = (count != 2'd2);
  assign head_valid = (count != 2'd0);
  assign head       = slots[rd_ptr];
  assign push       = push_valid && push_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end
endmodule

/* rtl/hco_back.sv */
// Back end: clears and writes the two bit-plane stores, reads cursor bits,
// resolves the final colour and buffers results. Depends on hco_pkg,
// hco_ram and hco_out_if.
module hco_back (
  input  logic            clk,
  input  logic            rst,
  input  hco_pkg::cfg_t   cfg,
  input  logic            head_valid,
  input  hco_pkg::entry_t head,
  output logic            pop,
  output logic            clearing,
  hco_out_if.source       result
);
  import hco_pkg::*;

  logic [INDEX_W-1:0]  clr_cnt;
  logic                we0;
  logic                we1;
  logic [INDEX_W-1:0]  waddr;
  logic [BYTE_W-1:0]   wdata;
  logic [BYTE_W-1:0]   rdata0;
  logic [BYTE_W-1:0]   rdata1;

  logic                s2_valid;
  logic                s2_hit;
  logic [2:0]          s2_bitsel;
  logic [COLOUR_W-1:0] s2_colour;
  logic [1:0]          code;
  logic [COLOUR_W-1:0] final_colour;

  logic [COLOUR_W-1:0] out_buf [3];
  logic [1:0]          out_wr;
  logic [1:0]          out_rd;
  logic [1:0]          out_cnt;
  logic                out_pop;
  logic [2:0]          pending;

  // Pixels may leave the queue only while the result buffer has a slot
  // reserved for them, counting the one still in the read stage.
  assign pending = {1'b0, out_cnt} + {2'b0, s2_valid};
  assign pop = head_valid && !clearing && (!head.is_pixel || (pending < 3'd3));

  always_comb begin
    waddr = clearing ? clr_cnt : head.index;
    wdata = clearing ? '0 : head.wbyte;
    we0   = clearing || (pop && !head.is_pixel && !head.plane);
    we1   = clearing || (pop && !head.is_pixel && head.plane);
  end

  hco_ram #(.WIDTH(BYTE_W), .DEPTH(PLANE_DEPTH)) u_plane0 (
    .clk   (clk),
    .we    (we0),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (head.index),
    .rdata (rdata0)
  );

  hco_ram #(.WIDTH(BYTE_W), .DEPTH(PLANE_DEPTH)) u_plane1 (
    .clk   (clk),
    .we    (we1),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (head.index),
    .rdata (rdata1)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_cnt  <= '0;
    end else if (clearing) begin
      clr_cnt <= clr_cnt + 1'b1;
      if (clr_cnt == INDEX_W'(PLANE_DEPTH - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= pop && head.is_pixel;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      s2_hit    <= head.hit;
      s2_bitsel <= head.bitsel;
      s2_colour <= head.colour;
    end
  end

  // Bit 0 of a byte's position is its MSB, the leftmost pixel.
  assign code = {rdata1[~s2_bitsel], rdata0[~s2_bitsel]};

  always_comb begin
    final_colour = s2_colour;
    if (s2_hit) begin
      case (cfg.mode)
        MODE_THREE: begin
          case (code)
            2'd1:    final_colour = cfg.colour_one;
            2'd2:    final_colour = cfg.colour_two;
            2'd3:    final_colour = cfg.colour_three;
            default: final_colour = s2_colour;
          endcase
        end
        MODE_XGA: begin
          case (code)
            2'd0:    final_colour = cfg.colour_one;
            2'd1:    final_colour = cfg.colour_two;
            2'd3:    final_colour = s2_colour ^ COLOUR_MASK;
            default: final_colour = s2_colour;
          endcase
        end
        MODE_XWIN: begin
          case (code)
            2'd2:    final_colour = cfg.colour_one;
            2'd3:    final_colour = cfg.colour_two;
            default: final_colour = s2_colour;
          endcase
        end
        default: final_colour = s2_colour;
      endcase
    end
  end

  assign out_pop           = result.valid && result.ready;
  assign result.valid      = (out_cnt != 2'd0);
  assign result.out_colour = out_buf[out_rd];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_wr  <= 2'd0;
      out_rd  <= 2'd0;
      out_cnt <= 2'd0;
    end else begin
      if (s2_valid) begin
        out_wr <= (out_wr == 2'd2) ? 2'd0 : out_wr + 2'd1;
      end
      if (out_pop) begin
        out_rd <= (out_rd == 2'd2) ? 2'd0 : out_rd + 2'd1;
      end
      out_cnt <= out_cnt + {1'b0, s2_valid} - {1'b0, out_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (s2_valid) begin
      out_buf[out_wr] <= final_colour;
    end
  end
endmodule

/* rtl/hardware_cursor_overlay.sv */
// Hardware cursor overlay, top level: configuration registers plus the
// front, queue and back. Depends on hco_pkg, hco_in_if, hco_out_if,
// hco_front, hco_queue and hco_back.
//
// Usage. The "item" channel carries one beat per item. A beat with op set
// to store writes store_byte into the 1 KB cursor image at store_addr
// (plane 0 below 512, plane 1 from 512 up) and produces no result. A beat
// with op set to pixel brings a screen pixel and yields exactly one beat on
// the "result" channel with the colour after the cursor overlay, in order.
// The user must write registers through cfg_we/cfg_index/cfg_data only
// while the block is idle; the block does not enforce this. The write takes
// effect at the next edge. Throughput is one beat per cycle, set by the
// single access each pixel makes to the two bit-plane memories, while
// result.ready stays high and no clearing pass runs. An accepted pixel
// beat passes through the queue, the memory read and the result buffer
// before its result beat is valid. After reset the registers read zero
// and a clearing pass zeroes both 512-byte plane memories, one address a
// cycle; item.ready stays low during the pass. When the receiver stalls,
// up to three results wait in the result buffer and two items in the
// queue before item.ready drops; stores at the queue head keep draining.
module hardware_cursor_overlay (
  input  logic                              clk,
  input  logic                              rst,
  hco_in_if.sink                            item,
  hco_out_if.source                         result,
  input  logic                              cfg_we,
  input  logic [hco_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [hco_pkg::COLOUR_W-1:0]      cfg_data
);
  import hco_pkg::*;

  cfg_t   cfg;
  logic   clearing;
  logic   push_valid;
  logic   push_ready;
  entry_t push_entry;
  logic   head_valid;
  entry_t head;
  logic   pop;

  // Register file: each field keeps only its own low bits of the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MODE:     cfg.mode         <= cfg_data[1:0];
        REG_BIG:      cfg.big          <= cfg_data[0];
        REG_QUADRANT: cfg.quadrant     <= cfg_data[1:0];
        REG_POS_X:    cfg.pos_x        <= cfg_data[POS_W-1:0];
        REG_POS_Y:    cfg.pos_y        <= cfg_data[POS_W-1:0];
        REG_COLOUR1:  cfg.colour_one   <= cfg_data;
        REG_COLOUR2:  cfg.colour_two   <= cfg_data;
        REG_COLOUR3:  cfg.colour_three <= cfg_data;
        default:      cfg              <= cfg;
      endcase
    end
  end

  // The front classifies each beat against the cursor window as it arrives.
  hco_front u_front (
    .item       (item),
    .cfg        (cfg),
    .clearing   (clearing),
    .push_ready (push_ready),
    .push_valid (push_valid),
    .push_entry (push_entry)
  );

  // The queue lets the front keep accepting while the back waits for room.
  hco_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_entry (push_entry),
    .push_ready (push_ready),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop)
  );

  // The back owns the plane memories, their clearing pass and the results.
  hco_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .clearing   (clearing),
    .result     (result)
  );
endmodule

/* tb/tb.sv */
// Self-checking testbench for the hardware cursor overlay (hardware_cursor_overlay).
// Depends on hco_pkg, hco_in_if, hco_out_if and hardware_cursor_overlay from the RTL.
`timescale 1ns / 100ps

module tb;
  import hco_pkg::*;

  // Generous bound on the whole run. The slowest legal run is roughly 800 beats
  // under the sparsest stall pattern, plus sender gaps and the clearing pass.
  localparam int CYCLE_LIMIT = 200000;
  // Cycles allowed after the last expected colour before a register write.
  // This gives trailing store beats time to leave the internal queue.
  localparam int SETTLE_CYCLES = 8;
  localparam int RANDOM_PHASES = 16;
  localparam int BEATS_PER_PHASE = 45;

  // Cursor codes, written as {plane 1 bit, plane 0 bit}.
  localparam logic [1:0] CODE_NONE = 2'b00;
  localparam logic [1:0] CODE_LO   = 2'b01;
  localparam logic [1:0] CODE_HI   = 2'b10;
  localparam logic [1:0] CODE_BOTH = 2'b11;

  typedef struct {
    logic                op;
    logic [ADDR_W-1:0]   addr;
    logic [BYTE_W-1:0]   data;
    logic [COORD_W-1:0]  x;
    logic [COORD_W-1:0]  y;
    logic [COLOUR_W-1:0] colour;
  } overlay_beat_t;

  logic                   clk;
  logic                   rst;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [COLOUR_W-1:0]    cfg_data;

  hco_in_if  item_if();
  hco_out_if result_if();

  hardware_cursor_overlay dut (
    .clk       (clk),
    .rst       (rst),
    .item      (item_if),
    .result    (result_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Shadow copy of the block's state. The image store mirrors both bit planes
  // (plane 1 from PLANE_DEPTH up), and the shadow registers follow every write.
  logic [BYTE_W-1:0]   cursor_image [0:2*PLANE_DEPTH-1];
  logic [1:0]          shadow_mode;
  logic                shadow_big;
  logic [1:0]          shadow_quadrant;
  logic [POS_W-1:0]    shadow_pos_x;
  logic [POS_W-1:0]    shadow_pos_y;
  logic [COLOUR_W-1:0] shadow_colour_one;
  logic [COLOUR_W-1:0] shadow_colour_two;
  logic [COLOUR_W-1:0] shadow_colour_three;

  overlay_beat_t       pending_beats[$];
  logic [COLOUR_W-1:0] expected_colours[$];

  int pushed_count   = 0;
  int accepted_count = 0;
  int error_count    = 0;
  int cycle_count    = 0;

  // Sender burst shaping and receiver stall pattern.
  int            burst_left = 0;
  int            gap_left   = 0;
  logic [15:0]   stall_pattern = 16'hffff;
  int            stall_age = 0;
  overlay_beat_t next_beat;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Colour that the block must return for one pixel under the current shadow
  // state. The window's top-left corner sits at the position registers minus
  // 64, so the window can start off screen and simply clip. In 32x32 mode the
  // quadrant register picks which quarter of the 64x64 image is shown; in
  // 64x64 mode it has no effect.
  function automatic logic [COLOUR_W-1:0] overlay_colour(
      logic [COORD_W-1:0] x, logic [COORD_W-1:0] y, logic [COLOUR_W-1:0] under);
    int          span;
    int          col;
    int          row;
    int          qx;
    int          qy;
    int          bit_index;
    logic [2:0]  shift;
    logic [7:0]  lo_byte;
    logic [7:0]  hi_byte;
    logic [1:0]  code;
    span = shadow_big ? 64 : 32;
    col  = int'(x) + WIN_OFFSET - int'(shadow_pos_x);
    row  = int'(y) + WIN_OFFSET - int'(shadow_pos_y);
    if (shadow_mode == MODE_OFF || col < 0 || col >= span || row < 0 || row >= span) begin
      return under;
    end
    qx = (!shadow_big && shadow_quadrant[0]) ? 32 : 0;
    qy = (!shadow_big && shadow_quadrant[1]) ? 32 : 0;
    bit_index = ((qy + row) * 64 + qx + col) % 4096;
    // Pixels are packed MSB first: the leftmost pixel of a byte is bit 7.
    shift   = 3'd7 - 3'(bit_index);
    lo_byte = cursor_image[bit_index / 8];
    hi_byte = cursor_image[PLANE_DEPTH + bit_index / 8];
    code    = {hi_byte[shift], lo_byte[shift]};
    case (shadow_mode)
      MODE_THREE: begin
        case (code)
          CODE_LO:   return shadow_colour_one;
          CODE_HI:   return shadow_colour_two;
          CODE_BOTH: return shadow_colour_three;
          default:   return under;
        endcase
      end
      MODE_XGA: begin
        // In XGA mode the "both" code inverts the pixel underneath.
        case (code)
          CODE_NONE: return shadow_colour_one;
          CODE_LO:   return shadow_colour_two;
          CODE_BOTH: return ~under;
          default:   return under;
        endcase
      end
      default: begin
        case (code)
          CODE_HI:   return shadow_colour_one;
          CODE_BOTH: return shadow_colour_two;
          default:   return under;
        endcase
      end
    endcase
  endfunction

  // Driver. Beats leave the pending queue in bursts of random length separated
  // by random gaps; some bursts are long and back to back so that the block
  // also sees stretches at full rate. Each accepted beat is applied to the
  // shadow state in acceptance order, which is the order the block sees.
  always @(posedge clk) begin
    if (!rst) begin
      if (item_if.valid && item_if.ready) begin
        if (item_if.op == OP_STORE) begin
          cursor_image[item_if.store_addr] = item_if.store_byte;
        end else begin
          expected_colours.push_back(overlay_colour(item_if.pixel_x, item_if.pixel_y,
                                                    item_if.pixel_colour));
        end
        accepted_count++;
      end
      if (!item_if.valid || item_if.ready) begin
        if (gap_left > 0 || pending_beats.size() == 0) begin
          if (gap_left > 0) begin
            gap_left--;
          end
          item_if.valid <= 1'b0;
        end else begin
          next_beat = pending_beats.pop_front();
          item_if.valid        <= 1'b1;
          item_if.op           <= next_beat.op;
          item_if.store_addr   <= next_beat.addr;
          item_if.store_byte   <= next_beat.data;
          item_if.pixel_x      <= next_beat.x;
          item_if.pixel_y      <= next_beat.y;
          item_if.pixel_colour <= next_beat.colour;
          burst_left--;
          if (burst_left <= 0) begin
            if ($urandom_range(0, 3) == 0) begin
              burst_left = $urandom_range(30, 80);
              gap_left   = 0;
            end else begin
              burst_left = $urandom_range(1, 12);
              gap_left   = $urandom_range(1, 6);
            end
          end
        end
      end
    end
  end

  // Monitor. Every result beat is checked against the oldest expected colour.
  // The ready line follows a rotating 16-bit stall pattern that is redrawn
  // whenever stall_age wraps: sometimes all ones, sometimes sparse, sometimes dense.
  always @(posedge clk) begin
    if (!rst && result_if.valid && result_if.ready) begin
      if (expected_colours.size() == 0) begin
        $display("%0t: unexpected result beat, expected none, actual %06h",
                 $time, result_if.out_colour);
        error_count++;
      end else if (result_if.out_colour !== expected_colours[0]) begin
        $display("%0t: out_colour mismatch, expected %06h, actual %06h",
                 $time, expected_colours[0], result_if.out_colour);
        error_count++;
        void'(expected_colours.pop_front());
      end else begin
        void'(expected_colours.pop_front());
      end
    end
    stall_age++;
    if (stall_age == 48) begin
      stall_age = 0;
      case ($urandom_range(0, 3))
        0:       stall_pattern = 16'hffff;
        1:       stall_pattern = 16'($urandom);
        2:       stall_pattern = 16'($urandom & $urandom);
        default: stall_pattern = 16'($urandom | $urandom);
      endcase
      stall_pattern[15] = 1'b1;
    end
    result_if.ready <= stall_pattern[0];
    stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic push_store(logic [ADDR_W-1:0] addr, logic [BYTE_W-1:0] data);
    overlay_beat_t beat;
    // Pixel fields are ignored on a store beat; fill them with noise.
    beat.op     = OP_STORE;
    beat.addr   = addr;
    beat.data   = data;
    beat.x      = COORD_W'($urandom);
    beat.y      = COORD_W'($urandom);
    beat.colour = COLOUR_W'($urandom);
    pending_beats.push_back(beat);
    pushed_count++;
  endtask

  task automatic push_pixel(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                            logic [COLOUR_W-1:0] colour);
    overlay_beat_t beat;
    beat.op     = OP_PIXEL;
    beat.addr   = ADDR_W'($urandom);
    beat.data   = BYTE_W'($urandom);
    beat.x      = x;
    beat.y      = y;
    beat.colour = colour;
    pending_beats.push_back(beat);
    pushed_count++;
  endtask

  // Waits until every pushed beat is accepted and every expected colour has
  // come back, then lets trailing store beats drain.
  task automatic settle();
    while (accepted_count != pushed_count || expected_colours.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_INDEX_W-1:0] index, logic [COLOUR_W-1:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    case (index)
      REG_MODE:     shadow_mode         = value[1:0];
      REG_BIG:      shadow_big          = value[0];
      REG_QUADRANT: shadow_quadrant     = value[1:0];
      REG_POS_X:    shadow_pos_x        = value[POS_W-1:0];
      REG_POS_Y:    shadow_pos_y        = value[POS_W-1:0];
      REG_COLOUR1:  shadow_colour_one   = value;
      REG_COLOUR2:  shadow_colour_two   = value;
      default:      shadow_colour_three = value;
    endcase
  endtask

  // Rewrites all eight registers once the block has gone idle.
  task automatic configure(logic [1:0] mode, logic big, logic [1:0] quadrant,
                           logic [POS_W-1:0] pos_x, logic [POS_W-1:0] pos_y,
                           logic [COLOUR_W-1:0] c1, logic [COLOUR_W-1:0] c2,
                           logic [COLOUR_W-1:0] c3);
    settle();
    write_reg(REG_MODE, COLOUR_W'(mode));
    write_reg(REG_BIG, COLOUR_W'(big));
    write_reg(REG_QUADRANT, COLOUR_W'(quadrant));
    write_reg(REG_POS_X, COLOUR_W'(pos_x));
    write_reg(REG_POS_Y, COLOUR_W'(pos_y));
    write_reg(REG_COLOUR1, c1);
    write_reg(REG_COLOUR2, c2);
    write_reg(REG_COLOUR3, c3);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Screen coordinate near the window edge along one axis, so most pixels land
  // inside the window or just around it. Falls back to anywhere on screen when
  // the drawn coordinate lies off screen.
  function automatic logic [COORD_W-1:0] near_window(logic [POS_W-1:0] pos, int span);
    int c;
    c = int'(pos) - WIN_OFFSET + int'($urandom_range(0, span + 7)) - 4;
    if (c < 0 || c > 2047) begin
      return COORD_W'($urandom_range(0, 2047));
    end
    return COORD_W'(c);
  endfunction

  initial begin
    int          span;
    int          qx;
    int          qy;
    int          row;
    int          col;
    logic [1:0]  mode;
    logic        big;
    logic [1:0]  quadrant;
    logic [POS_W-1:0]    pos_x;
    logic [POS_W-1:0]    pos_y;
    logic [COLOUR_W-1:0] c1;
    logic [COLOUR_W-1:0] c2;
    logic [COLOUR_W-1:0] c3;

    // Every input is at a known value from time zero.
    rst                  = 1'b1;
    cfg_we               = 1'b0;
    cfg_index            = REG_MODE;
    cfg_data             = '0;
    item_if.valid        = 1'b0;
    item_if.op           = OP_STORE;
    item_if.store_addr   = '0;
    item_if.store_byte   = '0;
    item_if.pixel_x      = '0;
    item_if.pixel_y      = '0;
    item_if.pixel_colour = '0;
    result_if.ready      = 1'b0;
    shadow_mode          = MODE_OFF;
    shadow_big           = 1'b0;
    shadow_quadrant      = '0;
    shadow_pos_x         = '0;
    shadow_pos_y         = '0;
    shadow_colour_one    = '0;
    shadow_colour_two    = '0;
    shadow_colour_three  = '0;
    foreach (cursor_image[i]) cursor_image[i] = '0;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed part. Right after reset the cursor is off, so the extreme
    // pixels must pass through unchanged.
    push_pixel('0, '0, '0);
    push_pixel('1, '1, '1);

    // Build the first image byte so that pixels 0..3 of row 0 carry the codes
    // lo, none, both, hi; the last byte of each plane makes pixel (63,63)
    // a "both" pixel.
    push_store(10'd0, 8'ha5);
    push_store(10'd512, 8'h3c);
    push_store(10'd511, 8'hff);
    push_store(10'd1023, 8'hff);

    // A 64x64 window at the top-left corner of the screen, shown in each
    // of the three cursor schemes. Column 64 lies just right of the window.
    for (int m = MODE_THREE; m <= MODE_XWIN; m++) begin
      configure(2'(m), 1'b1, 2'd3, 16'd64, 16'd64,
                COLOUR_W'($urandom), COLOUR_W'($urandom), COLOUR_W'($urandom));
      for (int x = 0; x < 4; x++) begin
        push_pixel(COORD_W'(x), '0, COLOUR_W'($urandom));
      end
      push_pixel(11'd63, 11'd63, COLOUR_W'($urandom));
      push_pixel(11'd64, 11'd0, COLOUR_W'($urandom));
    end

    // Random part. Each phase sweeps mode, window size and quadrant, with
    // some phases pinned to extreme positions and colours, then runs a mix of
    // store writes (half of them aimed at the bytes the window shows) and
    // pixels (mostly in and around the window).
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      mode     = 2'(phase % 4);
      big      = 1'((phase / 4) % 2);
      quadrant = 2'((phase + 2 * (phase / 8)) % 4);
      case (phase)
        0:       begin pos_x = '0;       pos_y = '0;       end
        1:       begin pos_x = '1;       pos_y = '1;       end
        2:       begin pos_x = 16'd64;   pos_y = 16'd64;   end
        3:       begin pos_x = 16'd2111; pos_y = 16'd2111; end
        5:       begin pos_x = 16'($urandom); pos_y = 16'($urandom_range(0, 2180)); end
        default: begin
          pos_x = 16'($urandom_range(0, 2180));
          pos_y = 16'($urandom_range(0, 2180));
        end
      endcase
      case (phase)
        7:       begin c1 = '1; c2 = '1; c3 = '1; end
        8:       begin c1 = '0; c2 = '0; c3 = '0; end
        default: begin
          c1 = COLOUR_W'($urandom);
          c2 = COLOUR_W'($urandom);
          c3 = COLOUR_W'($urandom);
        end
      endcase
      configure(mode, big, quadrant, pos_x, pos_y, c1, c2, c3);

      span = big ? 64 : 32;
      qx   = (!big && quadrant[0]) ? 32 : 0;
      qy   = (!big && quadrant[1]) ? 32 : 0;
      for (int n = 0; n < BEATS_PER_PHASE; n++) begin
        if ($urandom_range(0, 3) == 0) begin
          if ($urandom_range(0, 1) == 0) begin
            row = qy + $urandom_range(0, span - 1);
            col = qx + $urandom_range(0, span - 1);
            push_store({1'($urandom), 6'(row), 3'(col / 8)}, BYTE_W'($urandom));
          end else begin
            push_store(ADDR_W'($urandom), BYTE_W'($urandom));
          end
        end else if ($urandom_range(0, 4) == 0) begin
          push_pixel(COORD_W'($urandom), COORD_W'($urandom), COLOUR_W'($urandom));
        end else begin
          push_pixel(near_window(pos_x, span), near_window(pos_y, span),
                     COLOUR_W'($urandom));
        end
      end
    end

    settle();
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/hco_pkg.sv
rtl/hco_in_if.sv
rtl/hco_out_if.sv
rtl/hco_ram.sv
rtl/hco_front.sv
rtl/hco_queue.sv
rtl/hco_back.sv
rtl/hardware_cursor_overlay.sv
tb/tb.sv
